/* hw/rtl/sid_pkg.sv */
// Shared types and widths for the 2-D segment intersection pipeline.
`timescale 1ns / 1ps
package sid_pkg;

    localparam int COORD_BITS      = 16;
    localparam int EXTRA_FRAC_BITS = 8;
    localparam int OUT_BITS        = 24;

    // difference of two coordinates, one cross product, den/na/nb
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * COORD_BITS + 2;
    localparam int SUM_W  = 2 * COORD_BITS + 3;
    // magnitude of den (and of na after the range test)
    localparam int DEN_W  = 2 * COORD_BITS + 2;
    // quotient bits: |delta| << EXTRA_FRAC_BITS
    localparam int QUO_W  = COORD_BITS + EXTRA_FRAC_BITS;
    localparam int NUM_W  = DEN_W + QUO_W;
    localparam int PT_W   = COORD_BITS + EXTRA_FRAC_BITS + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_start_x;
        logic signed [COORD_BITS-1:0] a_start_y;
        logic signed [COORD_BITS-1:0] a_end_x;
        logic signed [COORD_BITS-1:0] a_end_y;
        logic signed [COORD_BITS-1:0] b_start_x;
        logic signed [COORD_BITS-1:0] b_start_y;
        logic signed [COORD_BITS-1:0] b_end_x;
        logic signed [COORD_BITS-1:0] b_end_y;
    } t_seg_in;

    typedef struct packed {
        logic                       hit;
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
    } t_seg_out;

    // per-item control that rides alongside the divider stages
    typedef struct packed {
        logic                         valid;
        logic                         hit;
        logic                         neg_x;
        logic                         neg_y;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
    } t_side;

endpackage

/* hw/rtl/sid_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module sid_div #(
    parameter int NUM_W = sid_pkg::NUM_W,
    parameter int DEN_W = sid_pkg::DEN_W,
    parameter int QUO_W = sid_pkg::QUO_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);
    import sid_pkg::*;

    // numerator must be below den << QUO_W, so the top part starts below den
    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_lo  [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DEN_W-1:0] s_rem;
        logic [DEN_W-1:0] s_den;
        logic [QUO_W-1:0] s_lo;
        logic [QUO_W-1:0] s_quo;
        logic [DEN_W:0]   s_trial;
        logic [DEN_W:0]   s_div;
        logic             s_ge;

        if (k == 0) begin : g_first
            assign s_rem = i_num[NUM_W-1:QUO_W];
            assign s_lo  = i_num[QUO_W-1:0];
            assign s_quo = '0;
            assign s_den = i_den;
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_lo  = r_lo[k-1];
            assign s_quo = r_quo[k-1];
            assign s_den = r_den[k-1];
        end

        assign s_trial = {s_rem, s_lo[QUO_W-1]};
        assign s_div   = {1'b0, s_den};
        assign s_ge    = s_trial >= s_div;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= s_ge ? DEN_W'(s_trial - s_div) : s_trial[DEN_W-1:0];
                r_lo[k]  <= s_lo << 1;
                r_quo[k] <= {s_quo[QUO_W-2:0], s_ge};
                r_den[k] <= s_den;
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

/* hw/rtl/segment_intersection_2d.sv */
// An accepted word passes 5 front stages, 24 divider stages and the output register
// on its way to its result word. Throughput: one word per cycle while the output is not stalled.
// The divider, one quotient bit per stage, sets the depth.
// The whole pipeline holds while the output word is stalled.
// Reset clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
module segment_intersection_2d (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sid_pkg::t_seg_in  i_data,
    output logic              o_stall,
    output logic              o_valid,
    output sid_pkg::t_seg_out o_data,
    input  logic              i_stall
);
    import sid_pkg::*;

    logic en;

    // stage 1: differences
    logic                         r1_valid;
    logic signed [DIFF_W-1:0]     r1_dxa, r1_dya, r1_dxb, r1_dyb, r1_ox, r1_oy;
    logic signed [COORD_BITS-1:0] r1_x1, r1_y1;
    // stage 2: products
    logic                         r2_valid, r2_zero;
    logic signed [PROD_W-1:0]     r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;
    logic signed [DIFF_W-1:0]     r2_dxa, r2_dya;
    logic signed [COORD_BITS-1:0] r2_x1, r2_y1;
    // stage 3: den, na, nb
    logic                         r3_valid, r3_zero;
    logic signed [SUM_W-1:0]      r3_den, r3_na, r3_nb;
    logic signed [DIFF_W-1:0]     r3_dxa, r3_dya;
    logic signed [COORD_BITS-1:0] r3_x1, r3_y1;
    // stage 4: range test
    logic                         r4_valid, r4_hit, r4_negx, r4_negy;
    logic [DEN_W-1:0]             r4_na, r4_den;
    logic [QUO_W-1:0]             r4_mag_x, r4_mag_y;
    logic signed [COORD_BITS-1:0] r4_x1, r4_y1;
    // stage 5: numerators
    logic [NUM_W-1:0]             r5_num_x, r5_num_y;
    logic [DEN_W-1:0]             r5_den;
    t_side                        r5_side;
    t_side                        r_side [QUO_W];
    logic                         r_out_valid;
    t_seg_out                     r_out;

    logic signed [SUM_W-1:0]      s4_den, s4_na, s4_nb;
    logic                         s4_neg, s4_hit;
    logic signed [DIFF_W-1:0]     s4_ax, s4_ay;
    logic [QUO_W-1:0]             quo_x, quo_y;
    logic signed [PT_W-1:0]       pt_x, pt_y, q_x, q_y;
    t_side                        side_last;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dxa <= DIFF_W'(i_data.a_end_x) - DIFF_W'(i_data.a_start_x);
            r1_dya <= DIFF_W'(i_data.a_end_y) - DIFF_W'(i_data.a_start_y);
            r1_dxb <= DIFF_W'(i_data.b_end_x) - DIFF_W'(i_data.b_start_x);
            r1_dyb <= DIFF_W'(i_data.b_end_y) - DIFF_W'(i_data.b_start_y);
            r1_ox  <= DIFF_W'(i_data.a_start_x) - DIFF_W'(i_data.b_start_x);
            r1_oy  <= DIFF_W'(i_data.a_start_y) - DIFF_W'(i_data.b_start_y);
            r1_x1  <= i_data.a_start_x;
            r1_y1  <= i_data.a_start_y;

            r2_p0   <= PROD_W'(r1_dyb) * PROD_W'(r1_dxa);
            r2_p1   <= PROD_W'(r1_dxb) * PROD_W'(r1_dya);
            r2_p2   <= PROD_W'(r1_dxb) * PROD_W'(r1_oy);
            r2_p3   <= PROD_W'(r1_dyb) * PROD_W'(r1_ox);
            r2_p4   <= PROD_W'(r1_dxa) * PROD_W'(r1_oy);
            r2_p5   <= PROD_W'(r1_dya) * PROD_W'(r1_ox);
            r2_zero <= (r1_dxa == '0 && r1_dya == '0) || (r1_dxb == '0 && r1_dyb == '0);
            r2_dxa  <= r1_dxa;
            r2_dya  <= r1_dya;
            r2_x1   <= r1_x1;
            r2_y1   <= r1_y1;

            r3_den  <= SUM_W'(r2_p0) - SUM_W'(r2_p1);
            r3_na   <= SUM_W'(r2_p2) - SUM_W'(r2_p3);
            r3_nb   <= SUM_W'(r2_p4) - SUM_W'(r2_p5);
            r3_zero <= r2_zero;
            r3_dxa  <= r2_dxa;
            r3_dya  <= r2_dya;
            r3_x1   <= r2_x1;
            r3_y1   <= r2_y1;

            r4_hit   <= s4_hit;
            // feed the divider a harmless 0 / 1 on a miss
            r4_na    <= s4_hit ? s4_na[DEN_W-1:0] : '0;
            r4_den   <= s4_hit ? s4_den[DEN_W-1:0] : DEN_W'(1);
            r4_negx  <= r3_dxa < 0;
            r4_negy  <= r3_dya < 0;
            r4_mag_x <= QUO_W'(s4_ax[COORD_BITS-1:0]) << EXTRA_FRAC_BITS;
            r4_mag_y <= QUO_W'(s4_ay[COORD_BITS-1:0]) << EXTRA_FRAC_BITS;
            r4_x1    <= r3_x1;
            r4_y1    <= r3_y1;

            r5_num_x        <= NUM_W'(r4_na) * NUM_W'(r4_mag_x);
            r5_num_y        <= NUM_W'(r4_na) * NUM_W'(r4_mag_y);
            r5_den          <= r4_den;
            r5_side.hit     <= r4_hit;
            r5_side.neg_x   <= r4_negx;
            r5_side.neg_y   <= r4_negy;
            r5_side.start_x <= r4_x1;
            r5_side.start_y <= r4_y1;

            r_out.hit     <= side_last.hit;
            r_out.cross_x <= side_last.hit ? OUT_BITS'(pt_x) : '0;
            r_out.cross_y <= side_last.hit ? OUT_BITS'(pt_y) : '0;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid      <= 1'b0;
            r2_valid      <= 1'b0;
            r3_valid      <= 1'b0;
            r4_valid      <= 1'b0;
            r5_side.valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else if (en) begin
            r1_valid      <= i_valid;
            r2_valid      <= r1_valid;
            r3_valid      <= r2_valid;
            r4_valid      <= r3_valid;
            r5_side.valid <= r4_valid;
            r_out_valid   <= side_last.valid;
        end
    end

    // normalize sign of den, then test both parameters against [0, 1]
    always_comb begin
        s4_neg = r3_den < 0;
        s4_den = s4_neg ? -r3_den : r3_den;
        s4_na  = s4_neg ? -r3_na  : r3_na;
        s4_nb  = s4_neg ? -r3_nb  : r3_nb;
        s4_hit = !r3_zero && (r3_den != '0) && (s4_na >= 0) && (s4_na <= s4_den)
              && (s4_nb >= 0) && (s4_nb <= s4_den);
        s4_ax  = (r3_dxa < 0) ? -r3_dxa : r3_dxa;
        s4_ay  = (r3_dya < 0) ? -r3_dya : r3_dya;
    end

    sid_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r5_num_x),
        .i_den (r5_den),
        .o_quo (quo_x)
    );

    sid_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r5_num_y),
        .i_den (r5_den),
        .o_quo (quo_y)
    );

    // sideband delay line matching the divider depth
    for (genvar k = 0; k < QUO_W; k++) begin : g_side
        t_side s_prev;

        if (k == 0) begin : g_head
            assign s_prev = r5_side;
        end else begin : g_tail
            assign s_prev = r_side[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k].valid <= 1'b0;
            end else if (en) begin
                r_side[k].valid <= s_prev.valid;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_side[k].hit     <= s_prev.hit;
                r_side[k].neg_x   <= s_prev.neg_x;
                r_side[k].neg_y   <= s_prev.neg_y;
                r_side[k].start_x <= s_prev.start_x;
                r_side[k].start_y <= s_prev.start_y;
            end
        end
    end

    assign side_last = r_side[QUO_W-1];

    // add the signed offset to the scaled start point
    always_comb begin
        q_x  = side_last.neg_x ? -PT_W'(quo_x) : PT_W'(quo_x);
        q_y  = side_last.neg_y ? -PT_W'(quo_y) : PT_W'(quo_y);
        pt_x = (PT_W'(side_last.start_x) <<< EXTRA_FRAC_BITS) + q_x;
        pt_y = (PT_W'(side_last.start_y) <<< EXTRA_FRAC_BITS) + q_y;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.hit) |-> (o_data.cross_x == '0 && o_data.cross_y == '0))
        else $error("miss word carries a nonzero point");

    a_range_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_valid && r4_hit) |-> (r4_na <= r4_den && r4_den != '0))
        else $error("hit with numerator above denominator");

    a_hold_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && o_stall) |=> (r1_valid && $stable(r1_dxa)))
        else $error("front stage lost a word under stall");

    a_side_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stall && side_last.valid) |=> o_valid)
        else $error("divider output word dropped");
`endif

endmodule
